@@ rtl/kst_pkg.sv @@
// kst_pkg: shared types and codes for the key state tracker
// holds function codes, phase codes, controller states and command/result structs
// no dependencies
package kst_pkg;

  localparam int KEY_W  = 25;
  localparam int FUNC_W = 3;

  localparam logic [FUNC_W-1:0] FN_PRESS   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TICK    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

  typedef enum logic [1:0] {
    PH_TRIG  = 2'd0,
    PH_PRESS = 2'd1,
    PH_REL   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXE
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic is_triggered;
    logic is_pressed;
    logic is_released;
    logic press_dropped;
  } result_t;

endpackage

@@ rtl/kst_if.sv @@
// kst_if: valid/ready channel interfaces for key state tracker transactions
// depends on kst_pkg for field widths
interface kst_in_if;
  import kst_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink   (input valid, input func, input key_code, output ready);
endinterface

interface kst_out_if;
  logic valid;
  logic ready;
  logic is_triggered;
  logic is_pressed;
  logic is_released;
  logic press_dropped;

  modport source (output valid, output is_triggered, output is_pressed,
                  output is_released, output press_dropped, input ready);
  modport sink   (input valid, input is_triggered, input is_pressed,
                  input is_released, input press_dropped, output ready);
endinterface

@@ rtl/key_state_tracker.sv @@
// key_state_tracker: bounded table of held keys with triggered/pressed/released phases
// capture, compare, then execute raises result valid once the result register is free
// a new transaction is taken only in idle, once the previous one has executed
// the result register lets the next transaction enter while a result waits
// reset clears all valid marks and the controller at once; no clearing pass
// depends on kst_pkg, kst_if, kst_ctrl, kst_dp
module key_state_tracker #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic       clk,
  input logic       rst_n,
  kst_in_if.sink    in_ch,
  kst_out_if.source out_ch
);
  import kst_pkg::*;

  cmd_t    cmd;
  result_t result;
  logic    in_ready;
  logic    out_valid;

  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  kst_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_func     (in_ch.func),
    .in_key_code (in_ch.key_code),
    .result      (result)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.is_triggered  = result.is_triggered;
  assign out_ch.is_pressed    = result.is_pressed;
  assign out_ch.is_released   = result.is_released;
  assign out_ch.press_dropped = result.press_dropped;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({result.is_triggered, result.is_pressed,
                            result.is_released, result.press_dropped}))
    else $error("more than one result flag set");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without an execute step");

  a_exec_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid || out_ch.ready))
    else $error("result register overwritten");

endmodule

@@ rtl/kst_ctrl.sv @@
// kst_ctrl: sequencing state machine for the key state tracker
// issues capture, compare and execute commands; owns the result valid flag
// depends on kst_pkg
module kst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output kst_pkg::cmd_t cmd
);
  import kst_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_EXE;
      end
      ST_EXE: begin
        // wait until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/kst_dp.sv @@
// kst_dp: entry table datapath with one compare cell per entry
// holds keys, phases and valid marks, the match/free vectors and the result register
// depends on kst_pkg
module kst_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kst_pkg::cmd_t             cmd,
  input  logic [kst_pkg::FUNC_W-1:0] in_func,
  input  logic [kst_pkg::KEY_W-1:0]  in_key_code,
  output kst_pkg::result_t          result
);
  import kst_pkg::*;

  logic [FUNC_W-1:0]        func_r;
  logic [KEY_W-1:0]         key_r;
  logic [KEY_W-1:0]         entry_key_r   [TABLE_ENTRIES];
  phase_t                   entry_phase_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid_r;
  logic [TABLE_ENTRIES-1:0] match_r;
  logic [TABLE_ENTRIES-1:0] free_oh_r;
  logic [TABLE_ENTRIES-1:0] match_nxt;
  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [1:0]               sel_phase;
  logic                     any_match;
  logic                     any_free;
  result_t                  result_r, result_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      key_r  <= in_key_code;
    end
  end

  // per-entry key compare
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_nxt[i] = entry_valid_r[i] && (entry_key_r[i] == key_r);
    end
  end

  assign free_vec = ~entry_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      match_r   <= match_nxt;
      // lowest free entry, one-hot
      free_oh_r <= free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});
    end
  end

  assign any_match = |match_r;
  assign any_free  = |free_oh_r;

  always_comb begin
    sel_phase = 2'b00;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sel_phase = sel_phase | ({2{match_r[i]}} & entry_phase_r[i]);
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        entry_valid_r[g] <= 1'b0;
      end else if (cmd.exec) begin
        case (func_r)
          FN_PRESS: begin
            if (!any_match && free_oh_r[g]) entry_valid_r[g] <= 1'b1;
          end
          FN_TICK: begin
            if (entry_phase_r[g] == PH_REL) entry_valid_r[g] <= 1'b0;
          end
          FN_CLEAR: begin
            entry_valid_r[g] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        case (func_r)
          FN_PRESS: begin
            if (!any_match && free_oh_r[g]) begin
              entry_key_r[g]   <= key_r;
              entry_phase_r[g] <= PH_TRIG;
            end
          end
          FN_RELEASE: begin
            if (match_r[g]) entry_phase_r[g] <= PH_REL;
          end
          FN_TICK: begin
            if (entry_valid_r[g] && entry_phase_r[g] == PH_TRIG) entry_phase_r[g] <= PH_PRESS;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result_nxt = '0;
    case (func_r)
      FN_PRESS: begin
        result_nxt.press_dropped = !any_match && !any_free;
      end
      FN_QUERY: begin
        result_nxt.is_triggered = any_match && (sel_phase == PH_TRIG);
        result_nxt.is_pressed   = any_match && (sel_phase == PH_PRESS);
        result_nxt.is_released  = any_match && (sel_phase == PH_REL);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for key_state_tracker, with a clocked driver, a clocked monitor
// and a local model of the key table that predicts the flags of every transaction
// depends on kst_pkg, kst_if and the key_state_tracker rtl
`timescale 1ns / 100ps

module tb;
  import kst_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int POOL_KEYS     = 24;
  localparam int RANDOM_EVENTS = 1400;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key_code;
    bit                drain;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n;

  kst_in_if  in_ch();
  kst_out_if out_ch();

  key_state_tracker #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  key_event_t       pending_events[$];
  result_t          expected_flags[$];
  logic [KEY_W-1:0] key_pool[POOL_KEYS];

  logic [KEY_W-1:0] held_key[TABLE_ENTRIES];
  bit               held_valid[TABLE_ENTRIES];
  phase_t           held_phase[TABLE_ENTRIES];

  int error_count    = 0;
  int accepted_count = 0;
  int result_count   = 0;
  int press_count    = 0;
  int drop_count     = 0;
  int query_count    = 0;
  int hit_count      = 0;
  int tick_count     = 0;
  int clear_count    = 0;
  int other_count    = 0;

  task automatic apply_key_event(input logic [FUNC_W-1:0] func,
                                 input logic [KEY_W-1:0] key_code, output result_t flags);
    int hit;
    int slot;
    hit  = -1;
    slot = -1;
    flags = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && held_valid[i] && held_key[i] == key_code) hit = i;
      if (slot < 0 && !held_valid[i]) slot = i;
    end
    case (func)
      FN_PRESS: begin
        press_count++;
        if (hit < 0) begin
          if (slot < 0) begin
            flags.press_dropped = 1'b1;
            drop_count++;
          end else begin
            held_key[slot]   = key_code;
            held_phase[slot] = PH_TRIG;
            held_valid[slot] = 1'b1;
          end
        end
      end
      FN_RELEASE: begin
        if (hit >= 0) held_phase[hit] = PH_REL;
      end
      FN_TICK: begin
        tick_count++;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (held_valid[i]) begin
            if (held_phase[i] == PH_TRIG) held_phase[i] = PH_PRESS;
            else if (held_phase[i] == PH_REL) held_valid[i] = 1'b0;
          end
        end
      end
      FN_QUERY: begin
        query_count++;
        if (hit >= 0) begin
          hit_count++;
          flags.is_triggered = held_phase[hit] == PH_TRIG;
          flags.is_pressed   = held_phase[hit] == PH_PRESS;
          flags.is_released  = held_phase[hit] == PH_REL;
        end
      end
      FN_CLEAR: begin
        clear_count++;
        for (int i = 0; i < TABLE_ENTRIES; i++) held_valid[i] = 1'b0;
      end
      default: begin
        other_count++;
      end
    endcase
  endtask

  task automatic check_flag(input string field, input logic expected, input logic actual);
    if (actual !== expected) begin
      $error("%s mismatch on result %0d: expected %0b, got %0b",
             field, result_count, expected, actual);
      error_count++;
    end
  endtask

  function automatic bit idle_roll(input int count);
    if (count >= 500 && count < 700) return 1'b0;
    return $urandom_range(0, 99) < 34;
  endfunction

  task automatic add_event(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key_code,
                           input bit drain);
    key_event_t ev;
    ev.func     = func;
    ev.key_code = key_code;
    ev.drain    = drain;
    pending_events.insert(pending_events.size(), ev);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom());
    return key_pool[$urandom_range(0, POOL_KEYS - 1)];
  endfunction

  // driver
  always @(posedge clk) begin : drive
    result_t flags;
    bit      hold;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_key_event(in_ch.func, in_ch.key_code, flags);
        expected_flags.insert(expected_flags.size(), flags);
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        hold = pending_events.size() > 0 && pending_events[0].drain &&
               expected_flags.size() != 0;
        if (pending_events.size() > 0 && !hold && !idle_roll(accepted_count)) begin
          in_ch.valid    <= 1'b1;
          in_ch.func     <= pending_events[0].func;
          in_ch.key_code <= pending_events[0].key_code;
          void'(pending_events.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    result_t exp_flags;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_flags.size() == 0) begin
          $error("result transaction with no expectation pending");
          error_count++;
        end else begin
          exp_flags = expected_flags.pop_front();
          check_flag("is_triggered", exp_flags.is_triggered, out_ch.is_triggered);
          check_flag("is_pressed", exp_flags.is_pressed, out_ch.is_pressed);
          check_flag("is_released", exp_flags.is_released, out_ch.is_released);
          check_flag("press_dropped", exp_flags.press_dropped, out_ch.press_dropped);
        end
        result_count++;
      end
      out_ch.ready <= !idle_roll(result_count);
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int roll;
    in_ch.valid    = 1'b0;
    in_ch.func     = FN_PRESS;
    in_ch.key_code = '0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) held_valid[i] = 1'b0;
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = KEY_W'($urandom());
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;

    // directed: extremes, present and absent keys, unknown functions
    add_event(FN_QUERY, '0, 1'b0);
    add_event(FN_PRESS, '0, 1'b0);
    add_event(FN_PRESS, KEY_MAX, 1'b0);
    add_event(FN_QUERY, '0, 1'b0);
    add_event(FN_QUERY, KEY_MAX, 1'b0);
    add_event(FN_PRESS, '0, 1'b0);
    add_event(FN_RELEASE, KEY_MAX, 1'b0);
    add_event(FN_PRESS, KEY_MAX, 1'b0);
    add_event(FN_QUERY, KEY_MAX, 1'b0);
    add_event(FN_RELEASE, 25'h0AAAAAA, 1'b0);
    add_event(FN_QUERY, 25'h1555555, 1'b0);
    add_event(FN_TICK, KEY_MAX, 1'b0);
    add_event(FN_QUERY, '0, 1'b0);
    add_event(FN_QUERY, KEY_MAX, 1'b0);
    add_event(FN_PRESS, '0, 1'b0);
    add_event(3'd5, KEY_MAX, 1'b0);
    add_event(3'd6, '0, 1'b0);
    add_event(3'd7, KEY_MAX, 1'b0);
    add_event(FN_QUERY, '0, 1'b0);
    add_event(FN_CLEAR, KEY_MAX, 1'b0);
    add_event(FN_QUERY, '0, 1'b0);

    // fill the table, then overflow it
    add_event(FN_CLEAR, KEY_W'($urandom()), 1'b1);
    for (int i = 0; i <= TABLE_ENTRIES; i++) add_event(FN_PRESS, key_pool[i], 1'b0);
    add_event(FN_QUERY, key_pool[TABLE_ENTRIES], 1'b0);
    add_event(FN_QUERY, key_pool[3], 1'b0);

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // burst of presses that tends to reach a full table
        for (int k = 0; k < 18; k++) add_event(FN_PRESS, pick_key(), 1'b0);
        n += 17;
      end else if (roll < 36) begin
        add_event(FN_PRESS, pick_key(), n == 700);
      end else if (roll < 55) begin
        add_event(FN_RELEASE, pick_key(), n == 700);
      end else if (roll < 65) begin
        add_event(FN_TICK, KEY_W'($urandom()), n == 700);
      end else if (roll < 94) begin
        add_event(FN_QUERY, pick_key(), n == 700);
      end else if (roll < 96) begin
        add_event(FN_CLEAR, KEY_W'($urandom()), n == 700);
      end else begin
        add_event(FUNC_W'($urandom_range(5, 7)), KEY_W'($urandom()), n == 700);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_events.size() != 0 || in_ch.valid || expected_flags.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d transactions: %0d presses (%0d dropped), %0d queries (%0d hits)",
             accepted_count, press_count, drop_count, query_count, hit_count);
    $display("plus %0d ticks, %0d clears, %0d unknown functions; %0d results checked",
             tick_count, clear_count, other_count, result_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
